// ===== src/ptb_pkg.sv =====
// Shared types, sizes and codes for the periodic timer bank.
package ptb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TIME_BITS  = 32;
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MASK_W     = 8;

  typedef enum logic [2:0] {
    K_CHECK  = 3'd0,
    K_ALLOC  = 3'd1,
    K_FREE   = 3'd2,
    K_PAUSE  = 3'd3,
    K_RESUME = 3'd4,
    K_CHANGE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NOT_USED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EXEC,
    S_RMW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now;
    logic [2:0]  slot;
    logic [31:0] period;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0] elapsed_mask;
    logic [2:0]        given_slot;
    status_t           status;
  } res_t;

  // One slot's timing record as kept in the slot memory.
  typedef struct packed {
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] last;
    logic [TIME_BITS-1:0] ptime;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  typedef struct packed {
    logic             we;
    logic [SLOT_W-1:0] addr;
    slot_rec_t        data;
  } ram_wr_t;

endpackage

// ===== src/ptb_in_if.sv =====
// Request channel: valid/ready handshake carrying one request word.
interface ptb_in_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            kind;
  logic [31:0]           now;
  logic [2:0]            slot;
  logic [31:0]           period;

  modport source (output valid, output kind, output now, output slot, output period,
                  input ready);
  modport sink   (input valid, input kind, input now, input slot, input period,
                  output ready);
endinterface

// ===== src/ptb_out_if.sv =====
// Response channel: valid/ready handshake carrying one response word.
interface ptb_out_if;
  logic                  valid;
  logic                  ready;
  logic [7:0]            elapsed_mask;
  logic [2:0]            given_slot;
  logic [1:0]            status;

  modport source (output valid, output elapsed_mask, output given_slot, output status,
                  input ready);
  modport sink   (input valid, input elapsed_mask, input given_slot, input status,
                  output ready);
endinterface

// ===== src/ptb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ptb_ctrl.sv =====
// Request sequencer: slot flags, elapsed bits and read-modify-write of the slot memory.
module ptb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  ptb_pkg::item_t    item,
  input  logic              item_valid,
  output logic              item_ready,
  output ptb_pkg::res_t     res,
  output logic              res_valid,
  input  logic              res_ready,
  output ptb_pkg::ram_wr_t  ram_wr,
  output logic [ptb_pkg::SLOT_W-1:0] ram_raddr,
  input  ptb_pkg::slot_rec_t ram_rdata
);
  import ptb_pkg::*;

  state_t                state, state_next;
  logic [2:0]            kind_q, kind_q_next;
  logic [TIME_BITS-1:0]  now_q, now_q_next;
  logic [2:0]            slot_q, slot_q_next;
  logic [TIME_BITS-1:0]  per_q, per_q_next;
  logic [SLOT_W:0]       cnt, cnt_next;
  logic                  rd_pend, rd_pend_next;
  logic [SLOT_W-1:0]     rd_idx, rd_idx_next;
  logic [NUM_TIMERS-1:0] in_use, in_use_next;
  logic [NUM_TIMERS-1:0] paused, paused_next;
  logic [NUM_TIMERS-1:0] elapsed, elapsed_next;
  logic [SLOT_W-1:0]     given_q, given_q_next;
  status_t               status_q, status_q_next;

  logic [SLOT_W-1:0]     sidx;
  logic                  slot_ok;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic [TIME_BITS-1:0]  diff;
  logic                  fire;
  slot_rec_t             rec;

  assign sidx    = SLOT_W'(slot_q);
  assign slot_ok = (32'(slot_q) < NUM_TIMERS) && in_use[sidx];
  assign diff    = now_q - ram_rdata.ptime - ram_rdata.last;
  assign fire    = in_use[rd_idx] && !paused[rd_idx] && (diff >= ram_rdata.period);

  // Lowest unused slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Show the elapsed flags in the response word, cast to its mask width.
  assign res.elapsed_mask = MASK_W'(elapsed);
  assign res.given_slot   = 3'(given_q);
  assign res.status       = status_q;
  assign res_valid        = (state == S_DONE);
  assign item_ready       = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    kind_q_next   = kind_q;
    now_q_next    = now_q;
    slot_q_next   = slot_q;
    per_q_next    = per_q;
    cnt_next      = cnt;
    rd_pend_next  = 1'b0;
    rd_idx_next   = rd_idx;
    in_use_next   = in_use;
    paused_next   = paused;
    elapsed_next  = elapsed;
    given_q_next  = given_q;
    status_q_next = status_q;
    ram_raddr     = sidx;
    ram_wr.we     = 1'b0;
    ram_wr.addr   = sidx;
    rec           = ram_rdata;
    ram_wr.data   = rec;

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          kind_q_next   = item.kind;
          now_q_next    = TIME_BITS'(item.now);
          slot_q_next   = item.slot;
          per_q_next    = TIME_BITS'(item.period);
          cnt_next      = '0;
          given_q_next  = '0;
          status_q_next = ST_OK;
          state_next    = (kind_t'(item.kind) == K_CHECK) ? S_CHECK : S_EXEC;
        end
      end

      S_CHECK: begin
        // Read the next slot while the previous one is evaluated.
        ram_raddr    = cnt[SLOT_W-1:0];
        rd_pend_next = (32'(cnt) < NUM_TIMERS);
        rd_idx_next  = cnt[SLOT_W-1:0];
        cnt_next     = cnt + 1'b1;
        if (rd_pend) begin
          elapsed_next[rd_idx] = fire;
          if (fire) begin
            rec.last    = now_q;
            rec.ptime   = '0;
            ram_wr.we   = 1'b1;
            ram_wr.addr = rd_idx;
            ram_wr.data = rec;
          end
        end
        if (32'(cnt) == NUM_TIMERS) begin
          state_next = S_DONE;
        end
      end

      S_EXEC: begin
        state_next = S_DONE;
        case (kind_t'(kind_q))
          K_ALLOC: begin
            if (free_found) begin
              in_use_next[free_idx]  = 1'b1;
              paused_next[free_idx]  = 1'b0;
              elapsed_next[free_idx] = 1'b0;
              rec.period  = per_q;
              rec.last    = now_q;
              rec.ptime   = '0;
              ram_wr.we   = 1'b1;
              ram_wr.addr = free_idx;
              ram_wr.data = rec;
              given_q_next = free_idx;
            end else begin
              status_q_next = ST_NO_FREE;
            end
          end
          K_FREE, K_PAUSE, K_RESUME, K_CHANGE: begin
            if (!slot_ok) begin
              status_q_next = ST_NOT_USED;
            end else begin
              case (kind_t'(kind_q))
                K_FREE: begin
                  in_use_next[sidx]  = 1'b0;
                  elapsed_next[sidx] = 1'b0;
                end
                K_PAUSE: begin
                  paused_next[sidx] = 1'b1;
                  state_next        = S_RMW;
                end
                K_RESUME: begin
                  paused_next[sidx] = 1'b0;
                  state_next        = S_RMW;
                end
                default: begin
                  elapsed_next[sidx] = 1'b0;
                  state_next         = S_RMW;
                end
              endcase
            end
          end
          default: begin
          end
        endcase
      end

      S_RMW: begin
        // Record of the addressed slot arrives now; patch and write back.
        case (kind_t'(kind_q))
          K_PAUSE:  rec.ptime = now_q;
          K_RESUME: rec.ptime = now_q - ram_rdata.ptime;
          default: begin
            rec.period = per_q;
            rec.last   = now_q;
          end
        endcase
        ram_wr.we   = 1'b1;
        ram_wr.data = rec;
        state_next  = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      rd_pend  <= 1'b0;
      in_use   <= '0;
      paused   <= '0;
      elapsed  <= '0;
      given_q  <= '0;
      status_q <= ST_OK;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      rd_pend  <= rd_pend_next;
      in_use   <= in_use_next;
      paused   <= paused_next;
      elapsed  <= elapsed_next;
      given_q  <= given_q_next;
      status_q <= status_q_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_q <= kind_q_next;
    now_q  <= now_q_next;
    slot_q <= slot_q_next;
    per_q  <= per_q_next;
    rd_idx <= rd_idx_next;
  end

endmodule

// ===== src/periodic_timer_bank_with_pause_top.sv =====
// Top level of the periodic timer bank: sequencer, slot memory and response register.
// A bank of periodic millisecond timers. Every request word carries the current time and
// a kind: check all, allocate, free, pause, resume or change period; each request yields
// exactly one response word with the elapsed bits, the granted slot and a status. Period,
// last expiry and pause time of each slot live in one memory with a registered read;
// in-use, paused and elapsed flags live in flip-flops. A check walks the slot memory one
// entry per cycle, the read of the next slot overlapped with the write-back of the current
// one. Pause, resume and change period on a slot in use read-modify-write one entry;
// allocate, free, unknown kinds and refused requests skip it. A new request is taken while
// the previous response still waits in its register.
module periodic_timer_bank_with_pause_top (
  input logic clk,
  input logic rst,
  ptb_in_if.sink    req,
  ptb_out_if.source rsp
);
  import ptb_pkg::*;

  item_t      item;
  res_t       res;
  logic       res_valid;
  logic       res_ready;
  ram_wr_t    ram_wr;
  logic [SLOT_W-1:0] ram_raddr;
  slot_rec_t  ram_rdata;
  logic [REC_W-1:0] rdata_raw;

  logic       out_valid;
  res_t       out_word;

  assign item.kind   = req.kind;
  assign item.now    = req.now;
  assign item.slot   = req.slot;
  assign item.period = req.period;

  ptb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (req.valid),
    .item_ready (req.ready),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .ram_wr     (ram_wr),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  ptb_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_TIMERS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (rdata_raw)
  );

  assign ram_rdata = slot_rec_t'(rdata_raw);

  // Hold the response word until the sink takes it.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.elapsed_mask = out_word.elapsed_mask;
  assign rsp.given_slot   = out_word.given_slot;
  assign rsp.status       = out_word.status;

endmodule
